[design/rau_pkg.sv]
// Package: shared types and codes for the rational arithmetic unit.
package rau_pkg;

    localparam int OPW = 16;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_NEG = 3'd4,
        ACT_CMP = 3'd5
    } action_t;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_DIV0 = 1'b1;

    typedef struct packed {
        logic [2:0]             action;
        logic signed [OPW-1:0]  a_num;
        logic [OPW-2:0]         a_den;
        logic signed [OPW-1:0]  b_num;
        logic [OPW-2:0]         b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         order;
        logic               status;
    } rau_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_OUT
    } state_t;

endpackage

[design/rau_gcd_div.sv]
// Shared shift/subtract unit: binary GCD and restoring division steps.
module rau_gcd_div
    import rau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start_gcd,
    input  logic        start_div,
    input  logic [63:0] op_x,
    input  logic [63:0] op_y,
    output logic        done,
    output logic [63:0] result
);

    logic [63:0] x_reg, x_next, y_reg, y_next, q_reg, q_next;
    logic [6:0]  k_reg, k_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        gbusy_reg, gbusy_next, dbusy_reg, dbusy_next, done_reg, done_next;
    logic [64:0] rem_sh;

    // One step per cycle: gcd reduction or one quotient bit
    always_comb
    begin
        x_next = x_reg; y_next = y_reg; q_next = q_reg; k_next = k_reg;
        cnt_next = cnt_reg; gbusy_next = gbusy_reg; dbusy_next = dbusy_reg;
        done_next = 1'b0;
        rem_sh = {x_reg, q_reg[63]};
        if (start_gcd)
        begin
            x_next = op_x; y_next = op_y; k_next = '0; gbusy_next = 1'b1;
        end
        else if (start_div)
        begin
            x_next = '0; q_next = op_x; y_next = op_y; cnt_next = 7'd64;
            dbusy_next = 1'b1;
        end
        else if (gbusy_reg)
        begin
            if (y_reg == 64'd0)
            begin
                q_next = x_reg << k_reg; gbusy_next = 1'b0; done_next = 1'b1;
            end
            else if (x_reg == 64'd0)
            begin
                x_next = y_reg; y_next = '0;
            end
            else if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1; y_next = y_reg >> 1; k_next = k_reg + 7'd1;
            end
            else if (!x_reg[0])
                x_next = x_reg >> 1;
            else if (!y_reg[0])
                y_next = y_reg >> 1;
            else if (x_reg >= y_reg)
                x_next = (x_reg - y_reg) >> 1;
            else
                y_next = (y_reg - x_reg) >> 1;
        end
        else if (dbusy_reg)
        begin
            if (rem_sh >= {1'b0, y_reg})
            begin
                x_next = 64'(rem_sh - {1'b0, y_reg});
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                x_next = rem_sh[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                dbusy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gbusy_reg <= 1'b0; dbusy_reg <= 1'b0; done_reg <= 1'b0;
            cnt_reg <= '0; k_reg <= '0;
        end
        else
        begin
            gbusy_reg <= gbusy_next; dbusy_reg <= dbusy_next; done_reg <= done_next;
            cnt_reg <= cnt_next; k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; y_reg <= y_next; q_reg <= q_next;
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule

[design/rational_arithmetic_unit_core.sv]
// Top level: rational arithmetic unit with gcd reduction.
//
// Input channel in_valid/in_ready carries one request (rau_in_t): an action
// and two fractions. Output channel out_valid/out_ready returns one result
// (rau_out_t) per request: reduced numerator and positive denominator, the
// compare order and a divide-by-zero status.
// One request at a time: in_ready is high only while the block is idle.
// From request accept to out_valid: only the multiply phase for an error,
// compare, unused action or zero numerator; otherwise the multiply phase,
// a binary gcd of one step per cycle (magnitudes stay below 2^32), then two
// 64-step divisions on the same shift/subtract unit.
// The shared gcd/divide unit sets how long a request takes. A new request
// is taken only after the result is handed off and the block is idle again.
// The result is held in an output register until taken; a stalled
// receiver holds the block in that state with no request taken.
// Reset clears all control state; no request is in flight after reset.
module rational_arithmetic_unit_core
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rau_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output rau_out_t out_data
);

    state_t state_reg, state_next;
    rau_in_t  req_reg;
    rau_out_t res_reg, res_next;
    logic signed [63:0] n_reg, n_next, d_reg, d_next, p1_reg, p2_reg;
    logic signed [OPW-1:0]   an, bn, ad, bd;
    logic signed [2*OPW-1:0] p_anbd, p_bnad, p_adbd, p_anbn, p_adbn;
    logic        neg_reg, neg_next, ph_reg;
    logic [63:0] un_reg, ud_reg, g_reg;
    logic        start_gcd, start_div, u_done;
    logic [63:0] op_x, op_y, u_res;

    rau_gcd_div u_unit (
        .clk(clk), .rst_n(rst_n), .start_gcd(start_gcd), .start_div(start_div),
        .op_x(op_x), .op_y(op_y), .done(u_done), .result(u_res)
    );

    assign an = req_reg.a_num;
    assign bn = req_reg.b_num;
    assign ad = {1'b0, req_reg.a_den};
    assign bd = {1'b0, req_reg.b_den};

    // Cross products of the operand-width fields, each 2*OPW bits wide
    assign p_anbd = an * bd;
    assign p_bnad = bn * ad;
    assign p_adbd = ad * bd;
    assign p_anbn = an * bn;
    assign p_adbn = ad * bn;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_MUL;
            S_MUL:
                if (ph_reg)
                    state_next = (res_next.status == ST_DIV0 || n_next == 0 ||
                                  req_reg.action > 3'(ACT_NEG)) ? S_OUT : S_GCD;
            S_GCD:  if (u_done) state_next = S_DIVN;
            S_DIVN: if (u_done) state_next = S_DIVD;
            S_DIVD: if (u_done) state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath control: products over the S_MUL phases, then gcd and divisions
    always_comb
    begin
        n_next = n_reg; d_next = d_reg; neg_next = neg_reg; res_next = res_reg;
        start_gcd = 1'b0; start_div = 1'b0; op_x = un_reg; op_y = ud_reg;
        if (state_reg == S_MUL && ph_reg)
        begin
            res_next = '{res_num: '0, res_den: 31'd1, order: ORD_LT, status: ST_OK};
            unique case (req_reg.action)
                3'(ACT_ADD): begin n_next = p1_reg + p2_reg; d_next = 64'(p_adbd); end
                3'(ACT_SUB): begin n_next = p1_reg - p2_reg; d_next = 64'(p_adbd); end
                3'(ACT_MUL): begin n_next = 64'(p_anbn); d_next = 64'(p_adbd); end
                3'(ACT_DIV): begin n_next = p1_reg; d_next = 64'(p_adbn); end
                3'(ACT_NEG): begin n_next = -(64'(an)); d_next = 64'(ad); end
                default:     begin n_next = '0; d_next = 64'sd1; end
            endcase
            if (req_reg.action == 3'(ACT_CMP))
                res_next.order = (p1_reg < p2_reg) ? ORD_LT :
                                 (p1_reg == p2_reg) ? ORD_EQ : ORD_GT;
            if (req_reg.action == 3'(ACT_DIV) && bn == 0)
                res_next.status = ST_DIV0;
            if (ad == 0 || bd == 0)
            begin
                res_next.status = ST_DIV0; res_next.order = ORD_LT;
            end
            neg_next = n_next[63] ^ d_next[63];
            start_gcd = 1'b1;
            op_x = n_next[63] ? 64'(-n_next) : 64'(n_next);
            op_y = d_next[63] ? 64'(-d_next) : 64'(d_next);
        end
        else if (state_reg == S_GCD && u_done)
        begin
            start_div = 1'b1; op_x = un_reg; op_y = u_res;
        end
        else if (state_reg == S_DIVN && u_done)
        begin
            start_div = 1'b1; op_x = ud_reg; op_y = g_reg;
            res_next.res_num = neg_reg ? 32'(-u_res) : u_res[31:0];
        end
        else if (state_reg == S_DIVD && u_done)
            res_next.res_den = u_res[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; ph_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= (state_reg == S_MUL) ? ~ph_reg : 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            req_reg <= in_data;
        if (state_reg == S_MUL && !ph_reg)
        begin
            p1_reg <= 64'(p_anbd);
            p2_reg <= 64'(p_bnad);
        end
        if (state_reg == S_MUL && ph_reg)
        begin
            un_reg <= op_x; ud_reg <= op_y;
        end
        if (state_reg == S_GCD && u_done)
            g_reg <= u_res;
        n_reg <= n_next; d_reg <= d_next; neg_reg <= neg_next; res_reg <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

endmodule
